### src/crcfr_pkg.sv
// shared types, constants and the crc table function for the frame receiver
`default_nettype none

package crcfr_pkg;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_OK     = 2'd1,
        EV_FORMAT = 2'd2,
        EV_CRC    = 2'd3
    } event_t;

    localparam logic [1:0] CFG_POLY   = 2'd0;
    localparam logic [1:0] CFG_BYPASS = 2'd1;
    localparam logic [1:0] CFG_START  = 2'd2;

    localparam logic [15:0] POLY_RESET   = 16'h1021;
    localparam logic [15:0] BYPASS_RESET = 16'hBADD;
    localparam logic [7:0]  START_RESET  = 8'hFF;

    typedef struct packed {
        event_t      event_res;
        logic [7:0]  command;
        logic [7:0]  frame_length;
        logic        payload_valid;
        logic [7:0]  payload_index;
        logic [7:0]  payload_byte;
        logic [31:0] ok_count;
        logic [31:0] format_error_count;
        logic [31:0] crc_error_count;
    } result_t;

    typedef struct packed {
        logic [15:0] crc_polynomial;
        logic [15:0] bypass_label;
        logic [7:0]  start_byte;
    } cfg_t;

    // msb-first table entry for one index byte, eight shift steps
    function automatic logic [15:0] crc_table_entry(input logic [7:0] idx,
                                                    input logic [15:0] poly);
        logic [15:0] r;
        r = {idx, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (r[15])
            begin
                r = {r[14:0], 1'b0} ^ poly;
            end
            else
            begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### src/crcfr_crc.sv
// one byte step of the augmented msb-first crc16
`default_nettype none

module crcfr_crc
    import crcfr_pkg::*;
(
    input  wire logic [15:0] crc_cur,
    input  wire logic [7:0]  data_byte,
    input  wire logic [15:0] poly,
    output logic [15:0]      crc_new
);

    always_comb
    begin
        crc_new = {crc_cur[7:0], data_byte} ^ crc_table_entry(crc_cur[15:8], poly);
    end

endmodule

`default_nettype wire

### src/crcfr_parser.sv
// frame parser: state registers and per-byte result logic
`default_nettype none

module crcfr_parser
    import crcfr_pkg::*;
#(
    parameter int POSITION_WRAP = 256
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] data_byte,
    input  wire cfg_t       cfg,
    output result_t         result
);

    localparam int POS_W = $clog2(POSITION_WRAP);
    localparam int CMP_W = (POS_W > 9) ? POS_W : 9;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             open_reg, open_next;
    logic [7:0]       len_reg, len_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic [15:0]      rcw_reg, rcw_next;
    logic [15:0]      crc_reg, crc_next;
    logic [31:0]      ok_reg, ok_next;
    logic [31:0]      fmt_reg, fmt_next;
    logic [31:0]      bad_reg, bad_next;

    logic [15:0]      crc_shift;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] len_ext;
    event_t           ev;
    logic [7:0]       len_out;
    logic             pv;
    logic [7:0]       pidx;
    logic [7:0]       pbyte;
    logic             start_hit;

    crcfr_crc u_crc (
        .crc_cur   (crc_reg),
        .data_byte (data_byte),
        .poly      (cfg.crc_polynomial),
        .crc_new   (crc_shift)
    );

    always_comb
    begin
        pos_ext   = CMP_W'(pos_reg);
        len_ext   = CMP_W'(len_reg);
        start_hit = !open_reg && (data_byte == cfg.start_byte);

        ev       = EV_NONE;
        len_out  = len_reg;
        pv       = 1'b0;
        pidx     = 8'd0;
        pbyte    = 8'd0;
        open_next = open_reg;
        len_next = len_reg;
        cmd_next = cmd_reg;
        rcw_next = rcw_reg;
        crc_next = crc_shift;

        if (start_hit)
        begin
            open_next = 1'b1;
            crc_next  = {8'h00, data_byte};
            rcw_next  = 16'h0000;
        end
        else if (pos_ext == CMP_W'(1))
        begin
            if (data_byte != 8'd0)
            begin
                ev = EV_FORMAT;
            end
        end
        else if (pos_ext == CMP_W'(2))
        begin
            len_out  = data_byte;
            len_next = data_byte;
            if (data_byte == 8'd0)
            begin
                ev = EV_FORMAT;
            end
        end
        else if (pos_ext == CMP_W'(3))
        begin
            cmd_next = data_byte;
        end
        else if (pos_ext > CMP_W'(3) && pos_ext < len_ext + CMP_W'(3))
        begin
            pv    = 1'b1;
            pidx  = 8'(pos_ext - CMP_W'(4));
            pbyte = data_byte;
        end
        else if (pos_ext == len_ext + CMP_W'(3))
        begin
            rcw_next = {data_byte, 8'h00};
        end
        else if (pos_ext == len_ext + CMP_W'(4))
        begin
            rcw_next = {rcw_reg[15:8], data_byte};
            if (crc_shift == 16'h0000 || rcw_next == cfg.bypass_label)
            begin
                ev = EV_OK;
            end
            else
            begin
                ev = EV_CRC;
            end
        end
        else
        begin
            ev = EV_FORMAT;
        end

        ok_next  = ok_reg;
        fmt_next = fmt_reg;
        bad_next = bad_reg;
        case (ev)
            EV_OK:     ok_next  = ok_reg + 32'd1;
            EV_FORMAT: fmt_next = fmt_reg + 32'd1;
            EV_CRC:    bad_next = bad_reg + 32'd1;
            default:   ;
        endcase

        // a frame end or a start both leave the position at one
        if (ev != EV_NONE)
        begin
            open_next = 1'b0;
            len_next  = 8'd0;
            pos_next  = POS_W'(1);
        end
        else if (start_hit)
        begin
            pos_next = POS_W'(1);
        end
        else if (pos_reg == POS_W'(POSITION_WRAP - 1))
        begin
            pos_next = '0;
        end
        else
        begin
            pos_next = pos_reg + POS_W'(1);
        end

        result.event_res          = ev;
        result.command            = cmd_next;
        result.frame_length       = len_out;
        result.payload_valid      = pv;
        result.payload_index      = pidx;
        result.payload_byte       = pbyte;
        result.ok_count           = ok_next;
        result.format_error_count = fmt_next;
        result.crc_error_count    = bad_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            open_reg <= 1'b0;
            len_reg  <= 8'd0;
            cmd_reg  <= 8'd0;
            rcw_reg  <= 16'h0000;
            crc_reg  <= 16'h0000;
            ok_reg   <= 32'd0;
            fmt_reg  <= 32'd0;
            bad_reg  <= 32'd0;
        end
        else if (step)
        begin
            pos_reg  <= pos_next;
            open_reg <= open_next;
            len_reg  <= len_next;
            cmd_reg  <= cmd_next;
            rcw_reg  <= rcw_next;
            crc_reg  <= crc_next;
            ok_reg   <= ok_next;
            fmt_reg  <= fmt_next;
            bad_reg  <= bad_next;
        end
    end

endmodule

`default_nettype wire

### src/crc16_checked_frame_receiver.sv
// Receiver for crc16-checked serial frames (start, zero, length, command, payload,
// crc high, crc low). One received byte is taken per transaction and gives exactly
// one result transaction. A new byte is accepted every clock cycle while not stalled;
// each byte is held in the input register, then the parse and table-driven crc step
// write its result into the result register; a result-side stall keeps it waiting.
// The table entry comes combinationally from the configured polynomial. Configuration
// writes are always taken (cfg_ready is high) and must only be issued while the block
// is idle.
`default_nettype none

module crc16_checked_frame_receiver
    import crcfr_pkg::*;
#(
    parameter int POSITION_WRAP = 256
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        rx_valid,
    output logic             rx_stall,
    input  wire logic [7:0]  rx_byte,

    output logic             res_valid,
    input  wire logic        res_stall,
    output logic [1:0]       event_res,
    output logic [7:0]       command,
    output logic [7:0]       frame_length,
    output logic             payload_valid,
    output logic [7:0]       payload_index,
    output logic [7:0]       payload_byte,
    output logic [31:0]      ok_count,
    output logic [31:0]      format_error_count,
    output logic [31:0]      crc_error_count,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    cfg_t        cfg_reg;
    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        res_valid_reg;
    result_t     res_reg;
    result_t     res_next;
    logic        out_free;
    logic        step;

    assign cfg_ready = 1'b1;
    assign out_free  = !res_valid_reg || !res_stall;
    assign step      = s1_valid_reg && out_free;
    assign rx_stall  = s1_valid_reg && !out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.crc_polynomial <= POLY_RESET;
            cfg_reg.bypass_label   <= BYPASS_RESET;
            cfg_reg.start_byte     <= START_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_POLY:   cfg_reg.crc_polynomial <= cfg_data;
                CFG_BYPASS: cfg_reg.bypass_label   <= cfg_data;
                CFG_START:  cfg_reg.start_byte     <= cfg_data[7:0];
                default:    ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!rx_stall)
        begin
            s1_valid_reg <= rx_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_valid && !rx_stall)
        begin
            s1_byte_reg <= rx_byte;
        end
    end

    crcfr_parser #(
        .POSITION_WRAP (POSITION_WRAP)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (s1_byte_reg),
        .cfg       (cfg_reg),
        .result    (res_next)
    );

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            res_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid          = res_valid_reg;
    assign event_res          = res_reg.event_res;
    assign command            = res_reg.command;
    assign frame_length       = res_reg.frame_length;
    assign payload_valid      = res_reg.payload_valid;
    assign payload_index      = res_reg.payload_index;
    assign payload_byte       = res_reg.payload_byte;
    assign ok_count           = res_reg.ok_count;
    assign format_error_count = res_reg.format_error_count;
    assign crc_error_count    = res_reg.crc_error_count;

    // a payload byte never closes a frame
    a_payload_no_event: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && payload_valid |-> event_res == EV_NONE)
        else $error("payload byte carries a frame event");

    // payload index stays inside the frame length
    a_payload_index: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && payload_valid |-> payload_index < frame_length)
        else $error("payload index beyond frame length");

    // input side only stalls while a byte waits in the input stage
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        rx_stall |-> s1_valid_reg && res_valid_reg && res_stall)
        else $error("input stalled without a blocked byte");

    // a byte reaches the result register via the input register when nothing stalls
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        rx_valid && !rx_stall ##1 !res_stall |=> res_valid)
        else $error("result missing after accepted byte");

endmodule

`default_nettype wire
